[rtl/bqc_pkg.sv]
// Shared types and constants of the biquad cascade filter.
`default_nettype none

package bqc_pkg;

	localparam int SIG_BITS     = 48;  // Q9.39 signal and state words
	localparam int SIG_FRAC     = 39;
	localparam int NCOEF        = 5;   // b0, b1, b2, a1, a2
	localparam int COUNT_BITS   = 4;   // section_count register
	localparam int SECSEL_BITS  = 3;   // coef_section field
	localparam int COEFSEL_BITS = 3;   // coef_select field

	typedef logic signed [SIG_BITS-1:0] sig_t;
	// Room for the sum of three signal words before saturation.
	typedef logic signed [SIG_BITS+1:0] acc_t;

	typedef enum logic [2:0] {
		OP_B0 = 3'd0,
		OP_B1 = 3'd1,
		OP_B2 = 3'd2,
		OP_A1 = 3'd3,
		OP_A2 = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} fsm_t;

	// Travels alongside a product through the multiplier pipeline.
	typedef struct packed {
		logic vld;
		op_t  op;
	} mac_tag_t;

endpackage

`default_nettype wire

[rtl/bqc_if.sv]
// Channel interfaces of the biquad cascade filter: items, results and configuration.
`default_nettype none

interface bqc_item_if
	import bqc_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 32
);
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          record_start;
	logic [SECSEL_BITS-1:0]        coef_section;
	logic [COEFSEL_BITS-1:0]       coef_select;
	logic signed [COEF_BITS-1:0]   coef_value;

	modport source (
		output valid, mode, sample_in, record_start, coef_section, coef_select, coef_value,
		input  ready
	);
	modport sink (
		input  valid, mode, sample_in, record_start, coef_section, coef_select, coef_value,
		output ready
	);
endinterface

interface bqc_result_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink (input valid, sample_out, saturated, output ready);
endinterface

interface bqc_cfg_if
	import bqc_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] section_count;

	modport source (output valid, section_count, input ready);
	modport sink (input valid, section_count, output ready);
endinterface

`default_nettype wire

[rtl/bqc_cmul.sv]
// Coefficient times signal: split magnitude multiply, round half away from zero, saturate.
`default_nettype none

module bqc_cmul
	import bqc_pkg::*;
#(
	parameter int COEF_BITS = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire mac_tag_t                tag_in,
	input  wire logic signed [COEF_BITS-1:0] coef,
	input  wire sig_t                    sig,
	output mac_tag_t                     tag_out,
	output sig_t                         prod
);

	localparam int HALF = SIG_BITS / 2;
	localparam int PW   = COEF_BITS + HALF;
	localparam int FW   = COEF_BITS + SIG_BITS;
	localparam int FRAC = COEF_BITS - 3;
	localparam int RW   = FW - FRAC;

	logic [COEF_BITS-1:0] cmag;
	logic [SIG_BITS-1:0]  xmag;
	logic                 neg;

	logic [PW-1:0]        plo_s2;
	logic [PW-1:0]        phi_s2;
	logic                 neg_s2;
	mac_tag_t             tag_s2;

	logic [FW-1:0]        full;
	logic [RW-1:0]        mrnd;
	logic [RW-1:0]        lim;
	logic [SIG_BITS-1:0]  mag;

	sig_t                 prod_s3;
	mac_tag_t             tag_s3;

	always_comb begin
		cmag = coef[COEF_BITS-1] ? $unsigned(-coef) : $unsigned(coef);
		xmag = sig[SIG_BITS-1] ? $unsigned(-sig) : $unsigned(sig);
		neg  = coef[COEF_BITS-1] ^ sig[SIG_BITS-1];
	end

	// Join the halves, round at the coefficient fraction, clip to the signal range.
	always_comb begin
		full = FW'(plo_s2) + (FW'(phi_s2) << HALF) + (FW'(1) << (FRAC - 1));
		mrnd = full[FW-1:FRAC];
		lim  = (RW'(1) << (SIG_BITS - 1)) - RW'(!neg_s2);
		mag  = (mrnd > lim) ? lim[SIG_BITS-1:0] : mrnd[SIG_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		plo_s2  <= PW'(cmag) * PW'(xmag[HALF-1:0]);
		phi_s2  <= PW'(cmag) * PW'(xmag[SIG_BITS-1:HALF]);
		neg_s2  <= neg;
		prod_s3 <= neg_s2 ? sig_t'(-mag) : sig_t'(mag);
	end

	assign tag_out = tag_s3;
	assign prod    = prod_s3;

endmodule

`default_nettype wire

[rtl/biquad_cascade_iir_filter.sv]
// Top level of the biquad cascade filter: sequencer, coefficient and state memories.
`default_nettype none

// Cascade of up to MAX_SECTIONS second-order sections in transposed direct form II.
// Items with mode 1 load one coefficient (section, select, value) and leave the block
// ready; items with mode 0 filter one sample. A sample runs through the first
// section_count sections (clipped to MAX_SECTIONS) on one shared multiplier that
// starts one coefficient product per cycle: five per section, with the multiplier's
// latency hidden by the order b0, b1, b2, a1, a2. No further item is accepted until
// the sample's result has been loaded into the output register; a section count of
// zero passes the sample through unchanged. The coefficients and the two state words
// of each section live in memories with one read and one write port and registered
// reads; record_start zeroes all state words at once through per-section valid bits,
// so no clearing pass is needed after reset. The result sits in an output register,
// so the next item is accepted while it waits. Coefficients must be written before a
// sample uses them; the user must see that section_count is changed only while idle;
// the block itself does not enforce it.
module biquad_cascade_iir_filter
	import bqc_pkg::*;
#(
	parameter int MAX_SECTIONS = 8,
	parameter int SAMPLE_BITS  = 24,
	parameter int COEF_BITS    = 32
) (
	input wire            clk,
	input wire            arst_n,
	bqc_item_if.sink      item,
	bqc_result_if.source  result,
	bqc_cfg_if.sink       cfg
);

	localparam int NCO      = MAX_SECTIONS * NCOEF;
	localparam int CA_W     = $clog2(NCO);
	localparam int SEC_W    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int IN_SHIFT = SIG_FRAC - (SAMPLE_BITS - 1);
	localparam int RND_W    = SIG_BITS - IN_SHIFT;
	localparam int CW_W     = SECSEL_BITS + 3;
	localparam logic [RND_W-1:0] POS_LIM = RND_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
	localparam logic [RND_W-1:0] NEG_LIM = POS_LIM + RND_W'(1);
	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	function automatic sig_t sat_sig(input acc_t v);
		logic [2:0] top;
		top = v[SIG_BITS+1:SIG_BITS-1];
		if (top == 3'b000 || top == 3'b111) begin
			sat_sig = v[SIG_BITS-1:0];
		end else if (v[SIG_BITS+1]) begin
			sat_sig = {1'b1, {(SIG_BITS-1){1'b0}}};
		end else begin
			sat_sig = {1'b0, {(SIG_BITS-1){1'b1}}};
		end
	endfunction

	// Control
	fsm_t                  state_q, state_d;
	logic [COUNT_BITS-1:0] section_count_q;
	logic [COUNT_BITS-1:0] eff_cnt;
	logic                  accept;
	logic                  load_out;
	op_t                   iss_op_q;
	logic [SEC_W-1:0]      iss_sec_q;
	logic [SEC_W-1:0]      last_sec_q;
	logic [SEC_W-1:0]      wr_sec_q;
	logic [CA_W-1:0]       coef_ra_q;
	mac_tag_t              tag_s1;
	mac_tag_t              tag_s3;
	logic                  st_we;
	logic                  done;

	// Coefficient memory
	logic [COEF_BITS-1:0]  coef_mem [NCO];
	logic [COEF_BITS-1:0]  coef_rd_q;
	logic [CW_W-1:0]       cw_full;
	logic                  cw_en;

	// State memory: {s1, s2} per section
	logic [2*SIG_BITS-1:0] st_mem [MAX_SECTIONS];
	logic [2*SIG_BITS-1:0] st_rd_q;
	logic [MAX_SECTIONS-1:0] st_vld_q;
	logic                  st_rd_vld_q;
	sig_t                  s1_old;
	sig_t                  s2_old;
	sig_t                  s2_new;

	// Datapath
	sig_t                  x_q;
	sig_t                  y_q;
	sig_t                  mul_sig;
	sig_t                  prod_s3;
	acc_t                  acc1_q;
	acc_t                  acc2_q;
	sig_t                  s1n_q;

	// Output rounding
	logic [SIG_BITS-1:0]   ymag;
	logic [SIG_BITS-1:0]   ysum;
	logic [RND_W-1:0]      yrnd;
	logic [SAMPLE_BITS-1:0] fin_sample;
	logic                  fin_sat;
	logic [SAMPLE_BITS-1:0] pend_sample_q;
	logic                  pend_sat_q;
	logic                  out_vld_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic                  out_sat_q;

	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;
	assign eff_cnt    = (int'(section_count_q) > MAX_SECTIONS) ? COUNT_BITS'(MAX_SECTIONS)
	                                                           : section_count_q;

	assign cw_full = CW_W'({item.coef_section, 2'b00}) + CW_W'(item.coef_section)
	               + CW_W'(item.coef_select);
	assign cw_en   = accept && item.mode && (int'(item.coef_select) < NCOEF)
	               && (int'(item.coef_section) < MAX_SECTIONS);

	assign st_we   = tag_s3.vld && (tag_s3.op == OP_A2);
	assign done    = st_we && (wr_sec_q == last_sec_q);

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && !item.mode) begin
					state_d = (eff_cnt == '0) ? ST_FIN : ST_RUN;
				end
			end
			ST_RUN: begin
				if (iss_op_q == OP_A2 && iss_sec_q == last_sec_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_vld_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			section_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				section_count_q <= cfg.section_count;
			end
		end
	end

	// Issue sequencer: one coefficient read per cycle, section by section.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_op_q    <= OP_B0;
			iss_sec_q   <= '0;
			last_sec_q  <= '0;
			wr_sec_q    <= '0;
			coef_ra_q   <= '0;
			tag_s1      <= '0;
			st_vld_q    <= '0;
			st_rd_vld_q <= 1'b0;
		end else begin
			tag_s1      <= '{vld: (state_q == ST_RUN), op: iss_op_q};
			st_rd_vld_q <= st_vld_q[iss_sec_q];
			if (accept && !item.mode) begin
				iss_op_q   <= OP_B0;
				iss_sec_q  <= '0;
				wr_sec_q   <= '0;
				coef_ra_q  <= '0;
				last_sec_q <= SEC_W'(eff_cnt - COUNT_BITS'(1));
				if (item.record_start) begin
					st_vld_q <= '0;
				end
			end else if (state_q == ST_RUN) begin
				coef_ra_q <= coef_ra_q + CA_W'(1);
				case (iss_op_q)
					OP_B0:   iss_op_q <= OP_B1;
					OP_B1:   iss_op_q <= OP_B2;
					OP_B2:   iss_op_q <= OP_A1;
					OP_A1:   iss_op_q <= OP_A2;
					default: begin
						iss_op_q  <= OP_B0;
						iss_sec_q <= iss_sec_q + SEC_W'(1);
					end
				endcase
			end
			if (st_we) begin
				st_vld_q[wr_sec_q] <= 1'b1;
				wr_sec_q           <= wr_sec_q + SEC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cw_en) begin
			coef_mem[CA_W'(cw_full)] <= item.coef_value;
		end
		coef_rd_q <= coef_mem[coef_ra_q];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[wr_sec_q] <= {s1n_q, s2_new};
		end
		st_rd_q <= st_mem[iss_sec_q];
	end

	// Feedback products use this section's output, the others its input.
	assign mul_sig = (tag_s1.op == OP_A1 || tag_s1.op == OP_A2) ? y_q : x_q;

	bqc_cmul #(
		.COEF_BITS (COEF_BITS)
	) u_cmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s1),
		.coef    (signed'(coef_rd_q)),
		.sig     (mul_sig),
		.tag_out (tag_s3),
		.prod    (prod_s3)
	);

	// Unwritten state words since the last record start read as zero.
	assign s1_old = st_rd_vld_q ? sig_t'(st_rd_q[2*SIG_BITS-1:SIG_BITS]) : '0;
	assign s2_old = st_rd_vld_q ? sig_t'(st_rd_q[SIG_BITS-1:0]) : '0;
	assign s2_new = sat_sig(acc2_q - acc_t'(prod_s3));

	always_ff @(posedge clk) begin
		if (accept && !item.mode) begin
			x_q <= sig_t'(item.sample_in) <<< IN_SHIFT;
		end else if (tag_s1.vld && tag_s1.op == OP_A2) begin
			// The next section takes this section's output.
			x_q <= y_q;
		end
		if (tag_s3.vld) begin
			case (tag_s3.op)
				OP_B0:   y_q    <= sat_sig(acc_t'(prod_s3) + acc_t'(s1_old));
				OP_B1:   acc1_q <= acc_t'(prod_s3) + acc_t'(s2_old);
				OP_B2:   acc2_q <= acc_t'(prod_s3);
				OP_A1:   s1n_q  <= sat_sig(acc1_q - acc_t'(prod_s3));
				default: ;
			endcase
		end
	end

	// Round the final signal to the sample format and clip.
	always_comb begin
		ymag       = y_q[SIG_BITS-1] ? $unsigned(-y_q) : $unsigned(y_q);
		ysum       = ymag + (SIG_BITS'(1) << (IN_SHIFT - 1));
		yrnd       = ysum[SIG_BITS-1:IN_SHIFT];
		fin_sat    = 1'b0;
		fin_sample = yrnd[SAMPLE_BITS-1:0];
		if (!y_q[SIG_BITS-1]) begin
			if (yrnd > POS_LIM) begin
				fin_sample = SMAX;
				fin_sat    = 1'b1;
			end
		end else begin
			if (yrnd > NEG_LIM) begin
				fin_sample = SMIN;
				fin_sat    = 1'b1;
			end else begin
				fin_sample = -yrnd[SAMPLE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !item.mode && eff_cnt == '0) begin
			pend_sample_q <= item.sample_in;
			pend_sat_q    <= 1'b0;
		end else if (done) begin
			pend_sample_q <= fin_sample;
			pend_sat_q    <= fin_sat;
		end
		if (load_out) begin
			out_sample_q <= pend_sample_q;
			out_sat_q    <= pend_sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.sample_out = out_sample_q;
	assign result.saturated  = out_sat_q;

endmodule

`default_nettype wire

[rtl/bqc_checker.sv]
// Port-level assertions of the biquad cascade filter, bound to its top level.
`default_nettype none

module bqc_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   item_valid,
	input wire                   item_ready,
	input wire                   item_mode,
	input wire                   res_valid,
	input wire                   res_ready,
	input wire [SAMPLE_BITS-1:0] res_sample,
	input wire                   res_saturated
);

	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Hold a result until its transfer.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before transfer");

	// A sample transfer starts work, so the next cycle takes no item.
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item_mode |=> !item_ready)
		else $error("item taken while a sample is in work");

	// A coefficient write leaves the block ready.
	a_coef_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_mode |=> item_ready)
		else $error("coefficient write stalled the input");

	// A clipped result sits at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_saturated |-> (res_sample == SMAX || res_sample == SMIN))
		else $error("saturated result not at a range limit");

endmodule

bind biquad_cascade_iir_filter bqc_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_bqc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_mode     (item.mode),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_sample    (result.sample_out),
	.res_saturated (result.saturated)
);

`default_nettype wire
